/* design/btzz_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btzz_pkg
// Shared constants and controller/datapath interface types for the zigzag
// binary tree traversal unit.
// ----------------------------------------------------------------------------
package btzz_pkg;

  localparam int MAX_NODES = 64;
  localparam int ID_W      = 7;
  localparam int ADDR_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic load_edge;
    logic start;
    logic pop;
    logic kids;
    logic push_a;
    logic push_b;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* design/binary_tree_zigzag_traversal_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// binary_tree_zigzag_traversal_unit
// Loads a binary tree as parent/child edges and emits its nodes in zigzag
// level order from root node 1, one result per node, last one marked.
// ----------------------------------------------------------------------------
// An edge transaction (operation 0) writes one child slot; edges naming ids
// outside 1..64 are dropped. A run transaction (operation 1) seeds the
// forward stack and then steps each emitted node through pop, child lookup,
// two pushes and hand-off to the output register, as separate steps set by
// the single write port of each stack and the registered reads of the stack
// and child-table memories; back-pressure on the result side stalls the
// hand-off step. A run emits at most 64 nodes. The child tables are cleared
// in the same cycle the last node is handed off, and the input is ready
// again in the next cycle, even while that last node waits.
// ----------------------------------------------------------------------------
module binary_tree_zigzag_traversal_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       operation,
  input  wire logic [btzz_pkg::ID_W-1:0]  parent_id,
  input  wire logic [btzz_pkg::ID_W-1:0]  child_id,
  input  wire logic                       is_right,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [btzz_pkg::ID_W-1:0]       node_id,
  output logic                            last_node
);
  import btzz_pkg::*;

  cmd_t    cmd;
  status_t status;

  btzz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  btzz_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .parent_id (parent_id),
    .child_id  (child_id),
    .is_right  (is_right),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .node_id   (node_id),
    .last_node (last_node)
  );

endmodule
`default_nettype wire

/* design/btzz_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btzz_ctrl
// Sequencer: loads edges, then steps each node of a run through pop, child
// lookup, two pushes and result hand-off.
// ----------------------------------------------------------------------------
module btzz_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             operation,
  input  wire btzz_pkg::status_t status,
  output btzz_pkg::cmd_t         cmd
);
  import btzz_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_KIDS  = 3'd3;
  localparam logic [2:0] S_PUSHA = 3'd4;
  localparam logic [2:0] S_PUSHB = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state, state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (operation == OP_RUN) begin
            state_next = S_START;
          end else begin
            cmd.load_edge = 1'b1;
          end
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_KIDS;
      end
      S_KIDS: begin
        cmd.kids   = 1'b1;
        state_next = S_PUSHA;
      end
      S_PUSHA: begin
        cmd.push_a = 1'b1;
        state_next = S_PUSHB;
      end
      S_PUSHB: begin
        cmd.push_b = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.last ? S_IDLE : S_POP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("more than one datapath command");
  a_run_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> cmd.pop) else $error("run start not followed by pop");
  a_pop_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> cmd.kids ##1 cmd.push_a ##1 cmd.push_b)
    else $error("node step sequence broken");

endmodule
`default_nettype wire

/* design/btzz_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btzz_dp
// Datapath: child tables with valid bits, two node stacks with depth
// counters, popped node, result count and the output register.
// ----------------------------------------------------------------------------
module btzz_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire btzz_pkg::cmd_t              cmd,
  output btzz_pkg::status_t                status,
  input  wire logic [btzz_pkg::ID_W-1:0]   parent_id,
  input  wire logic [btzz_pkg::ID_W-1:0]   child_id,
  input  wire logic                        is_right,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [btzz_pkg::ID_W-1:0]        node_id,
  output logic                             last_node
);
  import btzz_pkg::*;

  localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_NODES);

  logic [ID_W-1:0]      left_mem  [MAX_NODES];
  logic [ID_W-1:0]      right_mem [MAX_NODES];
  logic [MAX_NODES-1:0] left_vld, right_vld;
  logic [ID_W-1:0]      fwd_stack [MAX_NODES];
  logic [ID_W-1:0]      rev_stack [MAX_NODES];

  logic [ID_W-1:0]   fwd_depth, rev_depth, count;
  logic              phase_fwd;
  logic [ID_W-1:0]   fwd_rdata, rev_rdata, node;
  logic [ID_W-1:0]   left_data, right_data;
  logic              left_hit, right_hit;

  logic              edge_ok;
  logic [ADDR_W-1:0] edge_addr;
  logic [ID_W-1:0]   parent_m1, fwd_m1, rev_m1, popped, popped_m1;
  logic [ADDR_W-1:0] kid_addr;
  logic              sel_fwd;
  logic [ID_W-1:0]   left_kid, right_kid, push_id, tgt_depth;
  logic              push_ok;
  logic              fwd_we, rev_we;
  logic [ADDR_W-1:0] fwd_waddr, rev_waddr;
  logic [ID_W-1:0]   fwd_wdata;

  assign parent_m1 = parent_id - ID_W'(1);
  assign edge_addr = parent_m1[ADDR_W-1:0];
  assign edge_ok   = (parent_id != '0) && (parent_id <= MAX_ID) &&
                     (child_id != '0) && (child_id <= MAX_ID);

  assign fwd_m1    = fwd_depth - ID_W'(1);
  assign rev_m1    = rev_depth - ID_W'(1);
  assign sel_fwd   = phase_fwd ? (fwd_depth != '0) : (rev_depth == '0);

  assign popped    = phase_fwd ? fwd_rdata : rev_rdata;
  assign popped_m1 = popped - ID_W'(1);
  assign kid_addr  = popped_m1[ADDR_W-1:0];

  assign left_kid  = left_hit  ? left_data  : '0;
  assign right_kid = right_hit ? right_data : '0;

  // forward phase pushes left then right; reverse phase right then left
  always_comb begin
    if (cmd.push_a) begin
      push_id = phase_fwd ? left_kid : right_kid;
    end else begin
      push_id = phase_fwd ? right_kid : left_kid;
    end
  end

  assign tgt_depth = phase_fwd ? rev_depth : fwd_depth;
  assign push_ok   = (cmd.push_a || cmd.push_b) && (push_id != '0) &&
                     (tgt_depth < MAX_ID);

  assign fwd_we    = cmd.start || (push_ok && !phase_fwd);
  assign fwd_waddr = cmd.start ? '0 : fwd_depth[ADDR_W-1:0];
  assign fwd_wdata = cmd.start ? ID_W'(1) : push_id;
  assign rev_we    = push_ok && phase_fwd;
  assign rev_waddr = rev_depth[ADDR_W-1:0];

  assign status.last     = ((fwd_depth == '0) && (rev_depth == '0)) ||
                           (count == ID_W'(MAX_NODES - 1));
  assign status.out_free = !out_valid || out_ready;

  // child tables
  always_ff @(posedge clk) begin
    if (cmd.load_edge && edge_ok) begin
      if (is_right) begin
        right_mem[edge_addr] <= child_id;
      end else begin
        left_mem[edge_addr] <= child_id;
      end
    end
    if (cmd.kids) begin
      left_data  <= left_mem[kid_addr];
      right_data <= right_mem[kid_addr];
      left_hit   <= left_vld[kid_addr];
      right_hit  <= right_vld[kid_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.emit && status.last)) begin
      left_vld  <= '0;
      right_vld <= '0;
    end else if (cmd.load_edge && edge_ok) begin
      if (is_right) begin
        right_vld[edge_addr] <= 1'b1;
      end else begin
        left_vld[edge_addr] <= 1'b1;
      end
    end
  end

  // stacks
  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_stack[fwd_waddr] <= fwd_wdata;
    end
    if (rev_we) begin
      rev_stack[rev_waddr] <= push_id;
    end
    if (cmd.pop) begin
      fwd_rdata <= fwd_stack[fwd_m1[ADDR_W-1:0]];
      rev_rdata <= rev_stack[rev_m1[ADDR_W-1:0]];
    end
    if (cmd.kids) begin
      node <= popped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_depth <= '0;
      rev_depth <= '0;
      phase_fwd <= 1'b1;
      count     <= '0;
    end else begin
      if (cmd.start) begin
        fwd_depth <= ID_W'(1);
        rev_depth <= '0;
        phase_fwd <= 1'b1;
        count     <= '0;
      end else if (cmd.pop) begin
        phase_fwd <= sel_fwd;
        if (sel_fwd) begin
          fwd_depth <= fwd_m1;
        end else begin
          rev_depth <= rev_m1;
        end
      end else if (push_ok) begin
        if (phase_fwd) begin
          rev_depth <= rev_depth + ID_W'(1);
        end else begin
          fwd_depth <= fwd_depth + ID_W'(1);
        end
      end else if (cmd.emit && !status.last) begin
        count <= count + ID_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      node_id   <= node;
      last_node <= status.last;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (fwd_depth != '0) || (rev_depth != '0))
    else $error("pop with both stacks empty");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (fwd_depth <= MAX_ID) && (rev_depth <= MAX_ID))
    else $error("stack depth out of range");
  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.last |=> (left_vld == '0) && (right_vld == '0))
    else $error("child tables not cleared after run");
  a_node_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> node_id != '0) else $error("zero node id emitted");

endmodule
`default_nettype wire
